/* rtl/core/bmp24_to_rgb565_stream_core_macros.svh */
// Assertion macros for the BMP to RGB565 stream core.
`ifndef BMP24_TO_RGB565_STREAM_CORE_MACROS_SVH
`define BMP24_TO_RGB565_STREAM_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BMP24_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition never holds
`define BMP24_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* rtl/core/bmp565_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bmp565_pkg;

   localparam logic [1:0] KIND_PIXEL     = 2'd0;
   localparam logic [1:0] KIND_FORMAT    = 2'd1;
   localparam logic [1:0] KIND_SIGNATURE = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] color565;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type word;
   } req_slot_type;

   typedef struct packed {
      logic    valid;
      rsp_type word;
   } rsp_slot_type;

   typedef struct packed {
      logic take;
      logic advance;
   } pipe_ctl_type;

endpackage
`default_nettype wire

/* rtl/core/bmp565_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmp565_in_reg (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire bmp565_pkg::req_type        req_word,
   input  wire logic                       advance,
   output bmp565_pkg::req_slot_type        slot
);

   logic                valid_ff;
   bmp565_pkg::req_type word_ff;

   // hold the word while the parser cannot advance
   assign req_stall = valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         word_ff <= req_word;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.word  = word_ff;

endmodule
`default_nettype wire

/* rtl/core/bmp565_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmp565_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bmp565_pkg::req_slot_type slot,
   input  wire bmp565_pkg::pipe_ctl_type ctl,
   output bmp565_pkg::rsp_slot_type      result
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_PIXEL  = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_IDLE   = 3'd4;

   localparam logic [5:0] IDX_SIGNATURE = 6'd1;
   localparam logic [5:0] IDX_OFFSET    = 6'd13;
   localparam logic [5:0] IDX_WIDTH     = 6'd21;
   localparam logic [5:0] IDX_HEIGHT    = 6'd25;
   localparam logic [5:0] IDX_PLANES    = 6'd27;
   localparam logic [5:0] IDX_BPP       = 6'd29;
   localparam logic [5:0] IDX_COMPRESS  = 6'd33;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [31:0] HEADER_END    = 32'd34;

   logic [2:0]  phase_ff,  phase_in,  phase_cur;
   logic [31:0] count_ff,  count_in,  count_cur;
   logic [31:0] offset_ff, offset_in, offset_cur;
   logic [15:0] width_ff,  width_in,  width_cur;
   logic [15:0] height_ff, height_in, height_cur;
   logic [31:0] shift_ff,  shift_in,  shift_cur;
   logic [15:0] row_ff,    row_in,    row_cur;
   logic [15:0] col_ff,    col_in,    col_cur;
   logic [1:0]  tri_ff,    tri_in,    tri_cur;
   logic [7:0]  blue_ff,   blue_in,   blue_cur;
   logic [7:0]  green_ff,  green_in,  green_cur;
   logic [1:0]  pad_ff,    pad_in,    pad_cur;

   logic        restart;
   logic [7:0]  b;
   logic [31:0] shift_next;
   logic [31:0] count_next;
   logic [16:0] col_next;
   logic [16:0] row_next;
   logic        empty_image;
   logic        has_word;
   bmp565_pkg::rsp_type word;

   assign restart = slot.word.file_start;
   assign b       = slot.word.in_byte;

   // drop the old parse on a file start
   assign phase_cur  = restart ? PH_HEADER : phase_ff;
   assign count_cur  = restart ? '0 : count_ff;
   assign offset_cur = restart ? '0 : offset_ff;
   assign width_cur  = restart ? '0 : width_ff;
   assign height_cur = restart ? '0 : height_ff;
   assign shift_cur  = restart ? '0 : shift_ff;
   assign row_cur    = restart ? '0 : row_ff;
   assign col_cur    = restart ? '0 : col_ff;
   assign tri_cur    = restart ? '0 : tri_ff;
   assign blue_cur   = restart ? '0 : blue_ff;
   assign green_cur  = restart ? '0 : green_ff;
   assign pad_cur    = restart ? '0 : pad_ff;

   assign shift_next  = {b, shift_cur[31:8]};
   assign count_next  = count_cur + 32'd1;
   assign col_next    = {1'b0, col_cur} + 17'd1;
   assign row_next    = {1'b0, row_cur} + 17'd1;
   assign empty_image = (width_cur == 16'd0) || (height_cur == 16'd0);

   always_comb begin
      phase_in  = phase_cur;
      count_in  = count_cur;
      offset_in = offset_cur;
      width_in  = width_cur;
      height_in = height_cur;
      shift_in  = shift_cur;
      row_in    = row_cur;
      col_in    = col_cur;
      tri_in    = tri_cur;
      blue_in   = blue_cur;
      green_in  = green_cur;
      pad_in    = pad_cur;
      has_word  = 1'b0;
      word      = '0;
      unique case (phase_cur)
         PH_HEADER: begin
            shift_in = shift_next;
            count_in = count_next;
            unique case (count_cur[5:0])
               IDX_SIGNATURE: begin
                  if (shift_next[31:16] != BMP_SIGNATURE) begin
                     has_word  = 1'b1;
                     word.kind = bmp565_pkg::KIND_SIGNATURE;
                     phase_in  = PH_IDLE;
                  end
               end
               IDX_OFFSET: begin
                  offset_in = shift_next;
               end
               IDX_WIDTH: begin
                  width_in = shift_next[15:0];
               end
               IDX_HEIGHT: begin
                  height_in = shift_next[15:0];
               end
               IDX_PLANES: begin
                  if (shift_next[31:16] != 16'd1) begin
                     has_word  = 1'b1;
                     word.kind = bmp565_pkg::KIND_FORMAT;
                     phase_in  = PH_IDLE;
                  end
               end
               IDX_BPP: begin
                  if (shift_next[31:16] != 16'd24) begin
                     has_word  = 1'b1;
                     word.kind = bmp565_pkg::KIND_FORMAT;
                     phase_in  = PH_IDLE;
                  end
               end
               IDX_COMPRESS: begin
                  if ((shift_next != 32'd0) || (offset_cur < HEADER_END)) begin
                     has_word  = 1'b1;
                     word.kind = bmp565_pkg::KIND_FORMAT;
                     phase_in  = PH_IDLE;
                  end else if (offset_cur == HEADER_END) begin
                     row_in   = '0;
                     col_in   = '0;
                     tri_in   = '0;
                     pad_in   = '0;
                     phase_in = empty_image ? PH_IDLE : PH_PIXEL;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               default: begin
               end
            endcase
         end
         PH_SKIP: begin
            count_in = count_next;
            if (count_next >= offset_cur) begin
               row_in   = '0;
               col_in   = '0;
               tri_in   = '0;
               pad_in   = '0;
               phase_in = empty_image ? PH_IDLE : PH_PIXEL;
            end
         end
         PH_PIXEL: begin
            if (tri_cur == 2'd0) begin
               blue_in = b;
               tri_in  = 2'd1;
            end else if (tri_cur == 2'd1) begin
               green_in = b;
               tri_in   = 2'd2;
            end else begin
               tri_in          = 2'd0;
               has_word        = 1'b1;
               word.kind       = bmp565_pkg::KIND_PIXEL;
               word.pixel_x    = col_cur;
               word.pixel_y    = height_cur - 16'd1 - row_cur;
               word.color565   = {b[7:3], green_cur[7:2], blue_cur[7:3]};
               word.last_pixel = (col_next == {1'b0, width_cur}) &&
                                 (row_next == {1'b0, height_cur});
               col_in          = col_next[15:0];
               if (col_next >= {1'b0, width_cur}) begin
                  if (row_next >= {1'b0, height_cur}) begin
                     phase_in = PH_IDLE;
                  end else begin
                     row_in   = row_next[15:0];
                     col_in   = '0;
                     pad_in   = width_cur[1:0];
                     phase_in = (width_cur[1:0] != 2'd0) ? PH_PAD : PH_PIXEL;
                  end
               end
            end
         end
         PH_PAD: begin
            pad_in = pad_cur - 2'd1;
            if (pad_cur == 2'd1) begin
               phase_in = PH_PIXEL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= '0;
         offset_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         shift_ff  <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         tri_ff    <= '0;
         blue_ff   <= '0;
         green_ff  <= '0;
         pad_ff    <= '0;
      end else if (ctl.take) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         shift_ff  <= shift_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         tri_ff    <= tri_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         pad_ff    <= pad_in;
      end
   end

   assign result.valid = ctl.take && has_word;
   assign result.word  = word;

endmodule
`default_nettype wire

/* rtl/core/bmp565_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmp565_out_reg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bmp565_pkg::rsp_slot_type result,
   output logic                          advance,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output bmp565_pkg::rsp_type           rsp_word
);

   logic                valid_ff;
   bmp565_pkg::rsp_type word_ff;

   // advance when the slot is empty or being drained
   assign advance = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         word_ff <= result.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule
`default_nettype wire

/* rtl/core/bmp24_to_rgb565_stream_core.sv */
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  req_word: in_byte, file_start
// rsp      out        rsp_valid/rsp_stall  rsp_word: kind, pixel_x, pixel_y, color565, last_pixel
//
// One byte per clock sustained while rsp is not stalled; each byte gives zero or one word.
// A word shows on rsp once its byte has passed the input register, then the result register.
// Reset is synchronous and clears the parse to the header phase.
// A stall on rsp holds the result register and backs up into req_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp24_to_rgb565_stream_core_macros.svh"
module bmp24_to_rgb565_stream_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bmp565_pkg::req_type req_word,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output bmp565_pkg::rsp_type      rsp_word
);

   bmp565_pkg::req_slot_type slot;
   bmp565_pkg::rsp_slot_type result;
   bmp565_pkg::pipe_ctl_type ctl;
   logic                     advance;

   assign ctl.advance = advance;
   assign ctl.take    = slot.valid && advance;

   bmp565_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .advance   (ctl.advance),
      .slot      (slot)
   );

   bmp565_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .slot   (slot),
      .ctl    (ctl),
      .result (result)
   );

   bmp565_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   `BMP24_ASSERT_IMPL(a_status_clear, clock, reset, rsp_valid && (rsp_word.kind != bmp565_pkg::KIND_PIXEL), (rsp_word.pixel_x == 16'd0) && (rsp_word.pixel_y == 16'd0) && (rsp_word.color565 == 16'd0))
   `BMP24_ASSERT_NEVER(a_last_is_pixel, clock, reset, rsp_valid && rsp_word.last_pixel && (rsp_word.kind != bmp565_pkg::KIND_PIXEL))
   `BMP24_ASSERT_IMPL(a_word_has_source, clock, reset, $rose(rsp_valid), $past(slot.valid))

endmodule
`default_nettype wire

/* sim/bmp24_to_rgb565_stream_core_tb.sv */
`timescale 1ns / 1ps
module bmp24_to_rgb565_stream_core_tb;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          RANDOM_BYTES  = 300;
   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [31:0] HEADER_END    = 32'd34;

   typedef enum logic [2:0] {
      DEC_HEADER,
      DEC_SKIP,
      DEC_PIXEL,
      DEC_PAD,
      DEC_IDLE
   } decode_phase_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   bmp565_pkg::req_type req_word  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   bmp565_pkg::rsp_type rsp_word;

   bmp24_to_rgb565_stream_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // decoder state mirrored from the block
   decode_phase_type dec_phase;
   logic [31:0]      byte_count;
   logic [31:0]      data_offset;
   logic [15:0]      img_width;
   logic [15:0]      img_height;
   logic [31:0]      hdr_shift;
   logic [15:0]      row_index;
   logic [15:0]      col_index;
   logic [1:0]       triple;
   logic [7:0]       blue_hold;
   logic [7:0]       green_hold;
   logic [1:0]       pad_left;

   bmp565_pkg::req_type pending_bytes[$];
   bmp565_pkg::rsp_type expected_words[$];

   int      total_items    = 0;
   int      accepted_count = 0;
   int      cycle_count    = 0;
   int      fail_count     = 0;
   int      mismatch_count = 0;
   int      pixels_seen    = 0;
   int      status_seen    = 0;
   int      file_count     = 0;
   int      burst_left     = 1;
   int      gap_left       = 0;
   int      stall_mode     = 0;
   int      mode_left      = 0;
   bmp565_pkg::rsp_type want;

   task automatic clear_decode();
      dec_phase   = DEC_HEADER;
      byte_count  = '0;
      data_offset = '0;
      img_width   = '0;
      img_height  = '0;
      hdr_shift   = '0;
      row_index   = '0;
      col_index   = '0;
      triple      = '0;
      blue_hold   = '0;
      green_hold  = '0;
      pad_left    = '0;
   endtask

   task automatic start_image();
      row_index = '0;
      col_index = '0;
      triple    = '0;
      pad_left  = '0;
      if (img_width == 16'd0 || img_height == 16'd0) begin
         dec_phase = DEC_IDLE;
      end else begin
         dec_phase = DEC_PIXEL;
      end
   endtask

   task automatic decode_byte(input bmp565_pkg::req_type w);
      logic [31:0]         idx;
      bmp565_pkg::rsp_type word_out;
      bit                  has_word;
      word_out = '0;
      has_word = 1'b0;
      if (w.file_start) clear_decode();
      case (dec_phase)
         DEC_HEADER: begin
            idx        = byte_count;
            hdr_shift  = {w.in_byte, hdr_shift[31:8]};
            byte_count = idx + 32'd1;
            if (idx == 32'd1 && hdr_shift[31:16] != BMP_SIGNATURE) begin
               word_out.kind = bmp565_pkg::KIND_SIGNATURE;
               has_word      = 1'b1;
            end else if (idx == 32'd13) begin
               data_offset = hdr_shift;
            end else if (idx == 32'd21) begin
               img_width = hdr_shift[15:0];
            end else if (idx == 32'd25) begin
               img_height = hdr_shift[15:0];
            end else if (idx == 32'd27 && hdr_shift[31:16] != 16'd1) begin
               word_out.kind = bmp565_pkg::KIND_FORMAT;
               has_word      = 1'b1;
            end else if (idx == 32'd29 && hdr_shift[31:16] != 16'd24) begin
               word_out.kind = bmp565_pkg::KIND_FORMAT;
               has_word      = 1'b1;
            end else if (idx == 32'd33) begin
               if (hdr_shift != 32'd0 || data_offset < HEADER_END) begin
                  word_out.kind = bmp565_pkg::KIND_FORMAT;
                  has_word      = 1'b1;
               end else if (data_offset == HEADER_END) begin
                  start_image();
               end else begin
                  dec_phase = DEC_SKIP;
               end
            end
            if (has_word) dec_phase = DEC_IDLE;
         end
         DEC_SKIP: begin
            byte_count = byte_count + 32'd1;
            if (byte_count >= data_offset) start_image();
         end
         DEC_PIXEL: begin
            if (triple == 2'd0) begin
               blue_hold = w.in_byte;
               triple    = 2'd1;
            end else if (triple == 2'd1) begin
               green_hold = w.in_byte;
               triple     = 2'd2;
            end else begin
               triple              = 2'd0;
               word_out.kind       = bmp565_pkg::KIND_PIXEL;
               word_out.pixel_x    = col_index;
               word_out.pixel_y    = img_height - 16'd1 - row_index;
               word_out.color565   = {w.in_byte[7:3], green_hold[7:2], blue_hold[7:3]};
               word_out.last_pixel = ({16'd0, col_index} + 32'd1 == {16'd0, img_width}) &&
                                     ({16'd0, row_index} + 32'd1 == {16'd0, img_height});
               has_word            = 1'b1;
               col_index           = col_index + 16'd1;
               if (col_index >= img_width) begin
                  if ({16'd0, row_index} + 32'd1 >= {16'd0, img_height}) begin
                     dec_phase = DEC_IDLE;
                  end else begin
                     row_index = row_index + 16'd1;
                     col_index = '0;
                     pad_left  = img_width[1:0];
                     dec_phase = (pad_left != 2'd0) ? DEC_PAD : DEC_PIXEL;
                  end
               end
            end
         end
         DEC_PAD: begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 2'd0) dec_phase = DEC_PIXEL;
         end
         default: begin
         end
      endcase
      if (has_word) expected_words.push_back(word_out);
   endtask

   task automatic add_byte(input logic [7:0] b, input bit start_flag);
      bmp565_pkg::req_type w;
      w.in_byte    = b;
      w.file_start = start_flag;
      pending_bytes.push_back(w);
   endtask

   task automatic add_body(input int n);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic add_header(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] w32, input logic [31:0] h32,
                             input logic [15:0] planes, input logic [15:0] bpp,
                             input logic [31:0] comp, input bit start_flag, input int upto);
      logic [7:0] hdr [0:33];
      for (int i = 0; i < 34; i++) hdr[i] = 8'($urandom_range(0, 255));
      {hdr[1], hdr[0]}                   = sig;
      {hdr[13], hdr[12], hdr[11], hdr[10]} = offset;
      {hdr[21], hdr[20], hdr[19], hdr[18]} = w32;
      {hdr[25], hdr[24], hdr[23], hdr[22]} = h32;
      {hdr[27], hdr[26]}                 = planes;
      {hdr[29], hdr[28]}                 = bpp;
      {hdr[33], hdr[32], hdr[31], hdr[30]} = comp;
      for (int i = 0; i < upto; i++) add_byte(hdr[i], start_flag && (i == 0));
      file_count++;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_decode();
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            decode_byte(req_word);
            accepted_count++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_word  <= pending_bytes.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches between modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (cycle_count % 3 == 0);
            3: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (mismatch_count < 10) begin
               $display("unexpected word: kind %0d x %0d y %0d color %h last %0b",
                        rsp_word.kind, rsp_word.pixel_x, rsp_word.pixel_y,
                        rsp_word.color565, rsp_word.last_pixel);
            end
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (want.kind == bmp565_pkg::KIND_PIXEL) pixels_seen++;
            else status_seen++;
            if (rsp_word.kind !== want.kind || rsp_word.pixel_x !== want.pixel_x ||
                rsp_word.pixel_y !== want.pixel_y || rsp_word.color565 !== want.color565 ||
                rsp_word.last_pixel !== want.last_pixel) begin
               fail_count++;
               if (mismatch_count < 10) begin
                  $display("mismatch: expected kind %0d x %0d y %0d color %h last %0b",
                           want.kind, want.pixel_x, want.pixel_y, want.color565,
                           want.last_pixel);
                  $display("          actual   kind %0d x %0d y %0d color %h last %0b",
                           rsp_word.kind, rsp_word.pixel_x, rsp_word.pixel_y,
                           rsp_word.color565, rsp_word.last_pixel);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bmp24_to_rgb565_stream_core regression: fail");
         $finish;
      end
   end

   initial begin
      int          directed_count;
      int          pick;
      int          wd;
      int          ht;
      int          skip;
      int          need;
      logic [15:0] sig;
      logic [15:0] val16;
      logic [31:0] val32;

      // stream opens without a file start; extreme colors and row padding
      add_header(BMP_SIGNATURE, 34, 2, 2, 1, 24, 0, 1'b0, 34);
      add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
      add_byte(8'hAA, 1'b0); add_byte(8'h55, 1'b0);
      add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
      add_byte(8'h07, 1'b0); add_byte(8'hFC, 1'b0); add_byte(8'hF8, 1'b0);
      add_body(2);
      // bad signature
      add_byte(8'h42, 1'b1); add_byte(8'h4E, 1'b0); add_byte(8'hFF, 1'b0);
      file_count++;
      // bad planes, bad depth, compression set, offset too small
      add_header(BMP_SIGNATURE, 34, 1, 1, 0, 24, 0, 1'b1, 28);
      add_header(BMP_SIGNATURE, 34, 1, 1, 1, 32, 0, 1'b1, 30);
      add_header(BMP_SIGNATURE, 34, 1, 1, 1, 24, 1, 1'b1, 34);
      add_header(BMP_SIGNATURE, 33, 1, 1, 1, 24, 0, 1'b1, 34);
      // empty images
      add_header(BMP_SIGNATURE, 34, 0, 3, 1, 24, 0, 1'b1, 34);
      add_body(4);
      add_header(BMP_SIGNATURE, 34, 3, 0, 1, 24, 0, 1'b1, 34);
      add_body(4);
      // restart in the middle of the pixels; width with upper bits set
      add_header(BMP_SIGNATURE, 34, 32'hABCD_0003, 32'h1234_0002, 1, 24, 0, 1'b1, 34);
      add_body(5);
      // skip to offset, one pixel, bytes after the image
      add_header(BMP_SIGNATURE, 40, 1, 1, 1, 24, 0, 1'b1, 34);
      add_body(6 + 3 + 3);
      directed_count = pending_bytes.size();

      while (pending_bytes.size() < directed_count + RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            wd   = $urandom_range(1, 6);
            ht   = $urandom_range(1, 4);
            skip = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            need = skip + ht * 3 * wd + (ht - 1) * (wd % 4);
            add_header(BMP_SIGNATURE, 34 + skip, {16'($urandom), 16'(wd)},
                       {16'($urandom), 16'(ht)}, 1, 24, 0, 1'b1, 34);
            if ($urandom_range(0, 9) == 0) add_body($urandom_range(0, need - 1));
            else add_body(need + $urandom_range(0, 4));
         end else if (pick < 65) begin
            sig = 16'($urandom);
            if (sig == BMP_SIGNATURE) sig = ~sig;
            add_header(sig, 34, 1, 1, 1, 24, 0, 1'b1, $urandom_range(2, 34));
            add_body($urandom_range(0, 3));
         end else if (pick < 70) begin
            val16 = 16'($urandom);
            if (val16 == 16'd1) val16 = 16'd0;
            add_header(BMP_SIGNATURE, 34, 2, 2, val16, 24, 0, 1'b1, 34);
            add_body($urandom_range(0, 6));
         end else if (pick < 75) begin
            val16 = 16'($urandom);
            if (val16 == 16'd24) val16 = 16'd8;
            add_header(BMP_SIGNATURE, 34, 2, 2, 1, val16, 0, 1'b1, 34);
            add_body($urandom_range(0, 6));
         end else if (pick < 80) begin
            val32 = ($urandom_range(0, 1) == 0) ? $urandom : (32'd1 << $urandom_range(0, 31));
            if (val32 == 32'd0) val32 = 32'd1;
            add_header(BMP_SIGNATURE, 34, 2, 2, 1, 24, val32, 1'b1, 34);
            add_body($urandom_range(0, 6));
         end else if (pick < 84) begin
            add_header(BMP_SIGNATURE, $urandom_range(0, 33), 2, 2, 1, 24, 0, 1'b1, 34);
            add_body($urandom_range(0, 6));
         end else if (pick < 87) begin
            val32 = $urandom | 32'h0000_0100;
            add_header(BMP_SIGNATURE, val32, 2, 2, 1, 24, 0, 1'b1, 34);
            add_body($urandom_range(0, 20));
         end else if (pick < 90) begin
            wd = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
            ht = (wd == 0) ? $urandom_range(0, 4) : 0;
            add_header(BMP_SIGNATURE, 34, {16'($urandom), 16'(wd)},
                       {16'($urandom), 16'(ht)}, 1, 24, 0, 1'b1, 34);
            add_body($urandom_range(0, 8));
         end else if (pick < 93) begin
            add_header(BMP_SIGNATURE, 34, {16'($urandom), 8'hFF, 8'($urandom)},
                       $urandom, 1, 24, 0, 1'b1, 34);
            add_body($urandom_range(3, 40));
         end else begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)),
                                                   $urandom_range(0, 3) == 0);
         end
      end
      total_items = pending_bytes.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_items) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         fail_count += expected_words.size();
         $display("%0d expected words never arrived", expected_words.size());
      end
      $display("streamed %0d bytes in %0d files; checked %0d pixels and %0d status words",
               total_items, file_count, pixels_seen, status_seen);
      $display("mismatches and unexpected words: %0d", mismatch_count);
      if (fail_count == 0) begin
         $display("bmp24_to_rgb565_stream_core regression: pass");
      end else begin
         $display("bmp24_to_rgb565_stream_core regression: fail");
      end
      $finish;
   end
endmodule
